FILE: rtl/ptds_pkg.sv
// ----------------------------------------------------------------------------
// ptds_pkg
// Shared types and constants for the periodic task due scheduler.
// ----------------------------------------------------------------------------
package ptds_pkg;

  localparam int unsigned TASK_SLOTS = 16;
  localparam int unsigned IDX_W      = $clog2(TASK_SLOTS);
  localparam int unsigned CNT_W      = $clog2(TASK_SLOTS + 1);

  localparam logic [31:0] US_PER_MS = 32'd1000;
  localparam logic [31:0] HALF_WRAP = 32'h8000_0000;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_RUN   = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KIND_CLEARED = 3'd0,
    KIND_ADDED   = 3'd1,
    KIND_FULL    = 3'd2,
    KIND_DUE     = 3'd3,
    KIND_DONE    = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_RD,
    ST_CHK,
    ST_DIV,
    ST_WB,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] period;
    logic [31:0] next_due;
  } entry_t;

endpackage

FILE: rtl/periodic_task_due_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_task_due_scheduler
// Table of periodic tasks with add, clear and wrap-safe due-check passes.
// ----------------------------------------------------------------------------
// Clear and add each finish with a result strobe registered in the cycle
// after the work. A run pass reads the table one entry at a time from a
// synchronous RAM: an entry that is not due is passed over; a due entry with a
// nonzero period has its catch-up remainder found by a 32-step restoring
// divider, one bit per cycle, before write-back, and a due entry of period
// zero goes straight to write-back; a pass-done item ends the pass. busy is
// high while an item is at work; results come as single-cycle valid_o
// strobes that the receiver must take as they appear.
module periodic_task_due_scheduler
  import ptds_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          mode_i,
  input  logic [21:0]         period_ms_i,
  input  logic [31:0]         now_us_i,
  output logic                valid_o,
  output logic [2:0]          kind_o,
  output logic [IDX_W-1:0]    task_index_o,
  output logic [CNT_W-1:0]    task_count_o,
  output logic                last_o
);

  state_e state_q, state_d;

  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [31:0]      now_q, now_d;
  logic [31:0]      per_q, per_d;
  logic [31:0]      num_q, num_d;
  logic [31:0]      div_q, div_d;
  logic [31:0]      rem_q, rem_d;
  logic [4:0]       bit_q, bit_d;
  logic             big_q, big_d;

  logic             valid_q, valid_d;
  logic [2:0]       kind_q, kind_d;
  logic [IDX_W-1:0] oidx_q, oidx_d;
  logic [CNT_W-1:0] ocnt_q, ocnt_d;
  logic             last_q, last_d;

  entry_t           mem_q [TASK_SLOTS];
  entry_t           rd_q;
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;

  logic [31:0]      d_diff;
  logic [32:0]      rem_sh;
  logic [32:0]      rem_sub;
  logic [31:0]      next_due;
  logic [31:0]      adj;
  logic             last_entry;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[idx_q];
  end

  assign d_diff     = now_q - rd_q.next_due;
  assign rem_sh     = {rem_q, num_q[31]};
  assign rem_sub    = rem_sh - {1'b0, div_q};
  assign adj        = (rem_q != 32'd0) ? (div_q - rem_q) : 32'd0;
  assign last_entry = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;

  always_comb begin
    if (per_q == 32'd0) begin
      next_due = now_q + 32'd1;
    end else if (big_q) begin
      next_due = now_q + HALF_WRAP - adj;
    end else begin
      next_due = now_q - rem_q + per_q;
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    now_d   = now_q;
    per_d   = per_q;
    num_d   = num_q;
    div_d   = div_q;
    rem_d   = rem_q;
    bit_d   = bit_q;
    big_d   = big_q;
    valid_d = 1'b0;
    kind_d  = kind_q;
    oidx_d  = '0;
    ocnt_d  = ocnt_q;
    last_d  = 1'b0;
    we      = 1'b0;
    waddr   = idx_q;
    wdata   = '{period: per_q, next_due: next_due};

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          now_d = now_us_i;
          case (mode_i)
            MODE_CLEAR: begin
              count_d = '0;
              valid_d = 1'b1;
              kind_d  = KIND_CLEARED;
              ocnt_d  = '0;
              last_d  = 1'b1;
            end
            MODE_ADD: begin
              if (count_q == CNT_W'(TASK_SLOTS)) begin
                valid_d = 1'b1;
                kind_d  = KIND_FULL;
                ocnt_d  = count_q;
                last_d  = 1'b1;
              end else begin
                per_d   = {10'd0, period_ms_i} * US_PER_MS;
                state_d = ST_ADD;
              end
            end
            MODE_RUN: begin
              idx_d   = '0;
              state_d = (count_q == '0) ? ST_DONE : ST_RD;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADD: begin
        we      = 1'b1;
        waddr   = count_q[IDX_W-1:0];
        wdata   = '{period: per_q, next_due: now_q + per_q};
        count_d = count_q + CNT_W'(1);
        valid_d = 1'b1;
        kind_d  = KIND_ADDED;
        oidx_d  = count_q[IDX_W-1:0];
        ocnt_d  = count_q + CNT_W'(1);
        last_d  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_RD: begin
        state_d = ST_CHK;
      end
      ST_CHK: begin
        per_d = rd_q.period;
        if (d_diff[31]) begin
          if (last_entry) begin
            state_d = ST_DONE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_RD;
          end
        end else begin
          valid_d = 1'b1;
          kind_d  = KIND_DUE;
          oidx_d  = idx_q;
          ocnt_d  = count_q;
          rem_d   = '0;
          bit_d   = '0;
          big_d   = rd_q.period[31];
          if (rd_q.period[31]) begin
            num_d = HALF_WRAP - d_diff;
            div_d = 32'd0 - rd_q.period;
          end else begin
            num_d = d_diff;
            div_d = rd_q.period;
          end
          state_d = (rd_q.period == 32'd0) ? ST_WB : ST_DIV;
        end
      end
      ST_DIV: begin
        num_d = {num_q[30:0], 1'b0};
        rem_d = rem_sub[32] ? rem_sh[31:0] : rem_sub[31:0];
        bit_d = bit_q + 5'd1;
        if (bit_q == 5'd31) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        we = 1'b1;
        if (last_entry) begin
          state_d = ST_DONE;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = ST_RD;
        end
      end
      ST_DONE: begin
        valid_d = 1'b1;
        kind_d  = KIND_DONE;
        ocnt_d  = count_q;
        last_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    now_q  <= now_d;
    per_q  <= per_d;
    num_q  <= num_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
    bit_q  <= bit_d;
    big_q  <= big_d;
    kind_q <= kind_d;
    oidx_q <= oidx_d;
    ocnt_q <= ocnt_d;
    last_q <= last_d;
  end

  assign busy         = (state_q != ST_IDLE);
  assign valid_o      = valid_q;
  assign kind_o       = kind_q;
  assign task_index_o = oidx_q;
  assign task_count_o = ocnt_q;
  assign last_o       = last_q;

endmodule
